// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on aclk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define PTQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Implication checked at every rising edge outside reset.
`define PTQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ptq_pkg.sv =====
// ----------------------------------------------------------------------------
// Timer queue package
// Operation codes and the control word shared by the queue and its cells.
// ----------------------------------------------------------------------------
`default_nettype none
package ptq_pkg;

    localparam logic [1:0] OP_SCHEDULE = 2'd0;
    localparam logic [1:0] OP_CANCEL   = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic rm;   // remove the entry whose id matches, close the gap
        logic ins;  // insert the new entry at its ordered place
    } ptq_ctrl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ptq_cell.sv =====
// ----------------------------------------------------------------------------
// Timer queue cell
// One queue position: slot id, deadline and period, shifting left on removal
// and right on insertion.
// ----------------------------------------------------------------------------
`default_nettype none
module ptq_cell import ptq_pkg::*; #(
    parameter int IW = 3,
    parameter int TB = 32
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire ptq_ctrl_t     ctrl,
    input  wire logic [IW-1:0] tgt_id,
    input  wire logic [IW-1:0] new_id,
    input  wire logic [TB-1:0] new_dl,
    input  wire logic [TB-1:0] new_pd,
    input  wire logic [TB-1:0] new_key,
    input  wire logic [TB-1:0] cur_time,
    input  wire logic          left_valid,
    input  wire logic [IW-1:0] left_id,
    input  wire logic [TB-1:0] left_dl,
    input  wire logic [TB-1:0] left_pd,
    input  wire logic          right_valid,
    input  wire logic [IW-1:0] right_id,
    input  wire logic [TB-1:0] right_dl,
    input  wire logic [TB-1:0] right_pd,
    input  wire logic          rm_in,
    input  wire logic          found_in,
    output logic               valid,
    output logic [IW-1:0]      id,
    output logic [TB-1:0]      dl,
    output logic [TB-1:0]      pd,
    output logic               rm_out,
    output logic               found_out
);

    localparam logic [TB-1:0] SIGN = {1'b1, {(TB-1){1'b0}}};

    logic          valid_reg, valid_next;
    logic [IW-1:0] id_reg, id_next;
    logic [TB-1:0] dl_reg, dl_next;
    logic [TB-1:0] pd_reg, pd_next;
    logic          rm_seen, stop;
    logic [TB-1:0] key;

    assign rm_seen   = rm_in | (valid_reg && (id_reg == tgt_id));
    assign rm_out    = rm_seen;
    assign key       = (dl_reg - cur_time) ^ SIGN;
    assign stop      = !valid_reg || (key > new_key);
    assign found_out = found_in | stop;

    always_comb begin
        valid_next = valid_reg;
        id_next    = id_reg;
        dl_next    = dl_reg;
        pd_next    = pd_reg;
        if (ctrl.rm && rm_seen) begin
            valid_next = right_valid;
            id_next    = right_id;
            dl_next    = right_dl;
            pd_next    = right_pd;
        end else if (ctrl.ins) begin
            if (found_in) begin
                valid_next = left_valid;
                id_next    = left_id;
                dl_next    = left_dl;
                pd_next    = left_pd;
            end else if (stop) begin
                valid_next = 1'b1;
                id_next    = new_id;
                dl_next    = new_dl;
                pd_next    = new_pd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        id_reg <= id_next;
        dl_reg <= dl_next;
        pd_reg <= pd_next;
    end

    assign valid = valid_reg;
    assign id    = id_reg;
    assign dl    = dl_reg;
    assign pd    = pd_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/periodic_timer_queue.sv =====
// Sequence: schedule runs remove then insert, cancel runs remove, and tick repeats the head
// check per fire and inserts per re-arm; each result beat passes emit read, then emit write.
// Throughput: one item at a time; the next item is taken once the sequencer is
// back in idle, while the final result beat may still wait in the output register.
// The cell chain does one removal or one insertion a cycle.
// Reset: synchronous on aresetn low; the queue comes up empty and the time at zero.
// ----------------------------------------------------------------------------
// Periodic timer queue
// Deadline-ordered queue of periodic timer slots held in a chain of cells,
// driven by a small sequencer, with fire results buffered per tick.
// ----------------------------------------------------------------------------
`default_nettype none
module periodic_timer_queue import ptq_pkg::*; #(
    parameter int SLOTS     = 8,
    parameter int TIME_BITS = 32,
    parameter int MAX_FIRES = 64
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // operation[1:0], slot_id[4:2], period, current_time, keep_mask, zero padding
    input  wire logic [((2+3+2*TIME_BITS+8+7)/8)*8-1:0] s_tdata,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // fired_slot[2:0], active_count[6:3], zero padding
    output logic [7:0] m_tdata,
    // fired[0], overflow[1]
    output logic [1:0] m_tuser,
    output logic      m_tlast
);

    `include "assert_macros.svh"

    localparam int TB = TIME_BITS;
    localparam int IW = $clog2(SLOTS);
    localparam int LW = $clog2(SLOTS + 1);
    localparam int CW = $clog2(MAX_FIRES + 1);
    localparam int FA = (MAX_FIRES > 1) ? $clog2(MAX_FIRES) : 1;

    // Field offsets inside s_tdata.
    localparam int P_LO = 5;
    localparam int T_LO = P_LO + TB;
    localparam int K_LO = T_LO + TB;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_REMOVE  = 3'd1;
    localparam logic [2:0] ST_INSERT  = 3'd2;
    localparam logic [2:0] ST_CHECK   = 3'd3;
    localparam logic [2:0] ST_EMIT_RD = 3'd4;
    localparam logic [2:0] ST_EMIT_WR = 3'd5;

    localparam logic [TB-1:0] SIGN = {1'b1, {(TB-1){1'b0}}};

    logic [2:0]    state_reg;
    logic [1:0]    op_reg;
    logic [TB-1:0] time_reg;
    logic [IW-1:0] tgt_reg;
    logic [7:0]    keep_reg;
    logic [IW-1:0] ins_id_reg;
    logic [TB-1:0] ins_dl_reg;
    logic [TB-1:0] ins_pd_reg;
    logic [LW-1:0] len_reg;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] rd_ptr_reg;
    logic          ovf_reg;
    logic [2:0]    rd_data_reg;
    logic [2:0]    fire_mem [MAX_FIRES];

    logic          m_tvalid_reg;
    logic [7:0]    m_tdata_reg;
    logic [1:0]    m_tuser_reg;
    logic          m_tlast_reg;

    // Cell chain wiring.
    logic          cv   [SLOTS];
    logic [IW-1:0] cid  [SLOTS];
    logic [TB-1:0] cdl  [SLOTS];
    logic [TB-1:0] cpd  [SLOTS];
    logic          rmc  [SLOTS+1];
    logic          fnd  [SLOTS+1];
    logic [SLOTS-1:0] valid_vec;

    ptq_ctrl_t     ctrl;
    logic [IW-1:0] tgt_id;
    logic [TB-1:0] new_key;

    // Input fields.
    logic [1:0]    in_op;
    logic [2:0]    in_sid;
    logic [TB-1:0] in_period;
    logic [TB-1:0] in_time;
    logic [7:0]    in_keep;
    logic          in_sid_ok;

    assign in_op     = s_tdata[1:0];
    assign in_sid    = s_tdata[4:2];
    assign in_period = s_tdata[P_LO +: TB];
    assign in_time   = s_tdata[T_LO +: TB];
    assign in_keep   = s_tdata[K_LO +: 8];
    assign in_sid_ok = (32'(in_sid) < SLOTS);

    assign s_tready = (state_reg == ST_IDLE);

    // The head of the queue is expired when its signed distance from the
    // stored time is negative.
    logic          head_expired;
    logic [TB-1:0] head_dist;
    logic [2:0]    head_fs;
    logic          head_keep;
    logic          fire_limit;
    logic [TB-1:0] rearm_dl;

    assign head_dist    = cdl[0] - time_reg;
    assign head_expired = cv[0] && head_dist[TB-1];
    assign head_fs      = 3'(cid[0]);
    assign head_keep    = (32'(cid[0]) < 8) && keep_reg[head_fs];
    assign fire_limit   = (n_reg == CW'(MAX_FIRES));
    assign rearm_dl     = ((cdl[0] == '0) ? time_reg : cdl[0]) + cpd[0];
    assign new_key      = (ins_dl_reg - time_reg) ^ SIGN;

    always_comb begin
        ctrl.rm  = 1'b0;
        ctrl.ins = 1'b0;
        tgt_id   = tgt_reg;
        case (state_reg)
            ST_REMOVE: begin
                ctrl.rm = 1'b1;
            end
            ST_INSERT: begin
                ctrl.ins = 1'b1;
            end
            ST_CHECK: begin
                ctrl.rm = head_expired && !fire_limit;
                tgt_id  = cid[0];
            end
            default: begin
                ctrl.rm  = 1'b0;
            end
        endcase
    end

    assign rmc[0] = 1'b0;
    assign fnd[0] = 1'b0;

    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        logic          lv, rv;
        logic [IW-1:0] lid, rid;
        logic [TB-1:0] ldl, rdl, lpd, rpd;
        if (i == 0) begin : g_first
            assign lv  = 1'b0;
            assign lid = '0;
            assign ldl = '0;
            assign lpd = '0;
        end else begin : g_mid
            assign lv  = cv[i-1];
            assign lid = cid[i-1];
            assign ldl = cdl[i-1];
            assign lpd = cpd[i-1];
        end
        if (i == SLOTS - 1) begin : g_end
            assign rv  = 1'b0;
            assign rid = '0;
            assign rdl = '0;
            assign rpd = '0;
        end else begin : g_inner
            assign rv  = cv[i+1];
            assign rid = cid[i+1];
            assign rdl = cdl[i+1];
            assign rpd = cpd[i+1];
        end
        ptq_cell #(.IW(IW), .TB(TB)) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .tgt_id      (tgt_id),
            .new_id      (ins_id_reg),
            .new_dl      (ins_dl_reg),
            .new_pd      (ins_pd_reg),
            .new_key     (new_key),
            .cur_time    (time_reg),
            .left_valid  (lv),
            .left_id     (lid),
            .left_dl     (ldl),
            .left_pd     (lpd),
            .right_valid (rv),
            .right_id    (rid),
            .right_dl    (rdl),
            .right_pd    (rpd),
            .rm_in       (rmc[i]),
            .found_in    (fnd[i]),
            .valid       (cv[i]),
            .id          (cid[i]),
            .dl          (cdl[i]),
            .pd          (cpd[i]),
            .rm_out      (rmc[i+1]),
            .found_out   (fnd[i+1])
        );
        assign valid_vec[i] = cv[i];
    end

    // Fire buffer: slot ids of one tick, read back once the tick is finished
    // because every beat carries the final count and overflow flag.
    logic mem_we;
    assign mem_we = (state_reg == ST_CHECK) && head_expired && !fire_limit;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            fire_mem[n_reg[FA-1:0]] <= head_fs;
        end
        rd_data_reg <= fire_mem[rd_ptr_reg[FA-1:0]];
    end

    logic out_free;
    logic emit_last;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit_last = (n_reg == '0) || ((rd_ptr_reg + CW'(1)) == n_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            len_reg      <= '0;
            n_reg        <= '0;
            rd_ptr_reg   <= '0;
            ovf_reg      <= 1'b0;
            time_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // The emit state loads the next beat itself; elsewhere a taken
            // beat simply empties the output register.
            if (m_tvalid_reg && m_tready && (state_reg != ST_EMIT_WR)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        op_reg     <= in_op;
                        tgt_reg    <= IW'(in_sid);
                        keep_reg   <= in_keep;
                        ins_id_reg <= IW'(in_sid);
                        ins_dl_reg <= time_reg;
                        ins_pd_reg <= in_period;
                        n_reg      <= '0;
                        rd_ptr_reg <= '0;
                        ovf_reg    <= 1'b0;
                        if (in_op == OP_TICK) begin
                            time_reg  <= in_time;
                            state_reg <= ST_CHECK;
                        end else if ((in_op == OP_SCHEDULE || in_op == OP_CANCEL)
                                     && in_sid_ok) begin
                            state_reg <= ST_REMOVE;
                        end else begin
                            state_reg <= ST_EMIT_RD;
                        end
                    end
                end
                ST_REMOVE: begin
                    if (rmc[SLOTS]) begin
                        len_reg <= len_reg - LW'(1);
                    end
                    state_reg <= (op_reg == OP_SCHEDULE) ? ST_INSERT : ST_EMIT_RD;
                end
                ST_INSERT: begin
                    len_reg   <= len_reg + LW'(1);
                    state_reg <= (op_reg == OP_TICK) ? ST_CHECK : ST_EMIT_RD;
                end
                ST_CHECK: begin
                    if (!head_expired) begin
                        state_reg <= ST_EMIT_RD;
                    end else if (fire_limit) begin
                        ovf_reg   <= 1'b1;
                        state_reg <= ST_EMIT_RD;
                    end else begin
                        n_reg   <= n_reg + CW'(1);
                        len_reg <= len_reg - LW'(1);
                        if (head_keep) begin
                            ins_id_reg <= cid[0];
                            ins_dl_reg <= rearm_dl;
                            ins_pd_reg <= cpd[0];
                            state_reg  <= ST_INSERT;
                        end
                    end
                end
                ST_EMIT_RD: begin
                    state_reg <= ST_EMIT_WR;
                end
                ST_EMIT_WR: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {1'b0, 4'(len_reg),
                                         (n_reg != '0) ? rd_data_reg : 3'd0};
                        m_tuser_reg  <= {ovf_reg, (n_reg != '0)};
                        m_tlast_reg  <= emit_last;
                        if (emit_last) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            rd_ptr_reg <= rd_ptr_reg + CW'(1);
                            state_reg  <= ST_EMIT_RD;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // The length counter must track the occupied cells exactly.
    `PTQ_ASSERT(a_len_matches_cells, $countones(valid_vec) == 32'(len_reg),
        "queue length differs from occupied cells")
    // Occupied cells always form a prefix of the chain.
    `PTQ_ASSERT(a_cells_packed, ((valid_vec + 1'b1) & valid_vec) == '0,
        "gap in the cell chain")
    // Overflow is only reported on beats that carry a fired slot.
    `PTQ_ASSERT_IMP(a_ovf_fired, m_tvalid && m_tuser[1], m_tuser[0],
        "overflow flagged on a beat without a fire")
    // The fire buffer never runs past its depth.
    `PTQ_ASSERT(a_fire_bound, 32'(n_reg) <= MAX_FIRES, "fire count beyond limit")

endmodule
`default_nettype wire
